// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ubdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer descriptor table package
// Shared types, command and status codes, and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ubdt_pkg;

  localparam int NUM_DESCRIPTORS_DEF = 32;
  localparam int MAX_ENDPOINTS_DEF   = 16;

  localparam logic [11:0] ORIGIN_RST   = 12'h500;
  localparam logic [9:0]  CAPACITY_RST = 10'h300;

  localparam int B_UOWN   = 7;
  localparam int B_DTS    = 6;
  localparam int B_DTSEN  = 3;
  localparam int B_BSTALL = 2;

  localparam logic CFG_ORIGIN   = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef enum logic [3:0] {
    CMD_INIT     = 4'd0,
    CMD_SETUP    = 4'd1,
    CMD_LOOKUP   = 4'd2,
    CMD_PID      = 4'd3,
    CMD_RELEASE  = 4'd4,
    CMD_CLAIM    = 4'd5,
    CMD_GETBUF   = 4'd6,
    CMD_SENT     = 4'd7,
    CMD_STALL    = 4'd8,
    CMD_RECEIVE  = 4'd9,
    CMD_SEND     = 4'd10,
    CMD_SYNC     = 4'd11,
    CMD_SIE_DONE = 4'd12
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADPARM = 3'd1,
    ST_ERROR   = 3'd2,
    ST_NOMEM   = 3'd3,
    ST_ACCESS  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  count_low;
    logic [12:0] addr;
  } bd_entry_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  handle;
    logic [3:0]  pid;
    logic [12:0] addr;
    logic [9:0]  count;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/usb_buffer_descriptor_table.sv =====
// ----------------------------------------------------------------------------
// USB buffer descriptor table
// Descriptor store with buffer carving, ownership checks and size lookup.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low, and each command
// produces exactly one result word, shown for one cycle with out_valid; the
// receiver cannot stall it. Init, lookup and commands rejected on their inputs
// alone show their result in the cycle after acceptance. Commands that touch one
// descriptor read it in the evaluation state, which registers their result.
// Stall, receive, send and getbuf on an IN handle also need the buffer size,
// which the block finds in a scan state by reading the following descriptors
// through the single read port of the table RAM, one per cycle, until an
// allocated one is found or the highest set-up handle has been read.
// The next command can be accepted in the cycle that shows a result. Reset
// empties the table at once; no clearing pass is needed.
`default_nettype none

module usb_buffer_descriptor_table #(
  parameter int NUM_DESCRIPTORS = ubdt_pkg::NUM_DESCRIPTORS_DEF,
  parameter int MAX_ENDPOINTS   = ubdt_pkg::MAX_ENDPOINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [5:0]  in_bd_index,
  input  logic [4:0]  in_endpoint_number,
  input  logic        in_direction_in,
  input  logic [9:0]  in_byte_size,
  input  logic        in_sync_enable,
  input  logic        in_sync_value,
  input  logic [3:0]  in_token_pid,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_handle_out,
  output logic [3:0]  out_pid_out,
  output logic [12:0] out_buf_address,
  output logic [9:0]  out_byte_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(NUM_DESCRIPTORS);
  localparam int K_W   = IDX_W + 1;
  localparam int ENT_W = $bits(ubdt_pkg::bd_entry_t);
  localparam logic [6:0]     NUM_LIM = 7'(NUM_DESCRIPTORS);
  localparam logic [5:0]     EP_LIM  = 6'(MAX_ENDPOINTS);
  localparam logic [K_W-1:0] K_LIM   = K_W'(NUM_DESCRIPTORS);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SCAN} state_t;

  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ubdt_pkg::result_t     res_r, res_nxt, res_w;
  logic [11:0]           origin_r, origin_nxt;
  logic [9:0]            capacity_r, capacity_nxt;
  logic [12:0]           alloc_end_r, alloc_end_nxt;
  logic [IDX_W-1:0]      highest_r, highest_nxt;
  logic [NUM_DESCRIPTORS-1:0] valid_r, valid_nxt;
  ubdt_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [IDX_W-1:0]      h_r, h_nxt;
  logic [9:0]            size_r, size_nxt;
  logic                  sen_r, sen_nxt;
  logic                  sval_r, sval_nxt;
  logic [3:0]            pid_r, pid_nxt;
  ubdt_pkg::bd_entry_t   ent_r, ent_nxt, ent_w, rd_ent;
  logic [K_W-1:0]        k_r, k_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      rd_idx_r;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;

  ubdt_pkg::cmd_t        in_cmd;
  logic [5:0]            setup_h;
  logic [IDX_W-1:0]      idle_h;
  logic                  range_ok, ep_ok, is_in, owned, fin;
  logic                  cfg_wr, cfg_sel;
  logic [12:0]           used13, room13, scan_size;
  logic                  nomem, hit, k_done;

  ubdt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_DESCRIPTORS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(h_r),
    .wdata(ent_w),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_cmd   = ubdt_pkg::cmd_t'(in_command);
  assign setup_h  = {in_endpoint_number, in_direction_in};
  assign idle_h   = (in_cmd == ubdt_pkg::CMD_SETUP) ? setup_h[IDX_W-1:0]
                                                    : in_bd_index[IDX_W-1:0];
  assign range_ok = {1'b0, in_bd_index} < NUM_LIM;
  assign ep_ok    = {1'b0, in_endpoint_number} < EP_LIM;
  assign is_in    = in_bd_index[0];

  assign rd_ent   = valid_r[rd_idx_r] ? ubdt_pkg::bd_entry_t'(ram_rdata) : '0;
  assign owned    = rd_ent.status[ubdt_pkg::B_UOWN];

  assign used13   = alloc_end_r - {1'b0, origin_r};
  assign room13   = {3'b0, capacity_r} - used13;
  assign nomem    = (used13 > {3'b0, capacity_r}) || (room13 < {3'b0, size_r});

  assign hit       = pend_r && (rd_ent.addr != 13'd0);
  assign k_done    = (k_r > K_W'(highest_r)) || (k_r >= K_LIM);
  assign scan_size = hit ? (rd_ent.addr - ent_r.addr) : (alloc_end_r - ent_r.addr);

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (cfg_sel == ubdt_pkg::CFG_CAPACITY) ? {22'd0, capacity_r}
                                                       : {20'd0, origin_r};

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    res_w         = '0;
    origin_nxt    = origin_r;
    capacity_nxt  = capacity_r;
    alloc_end_nxt = alloc_end_r;
    highest_nxt   = highest_r;
    valid_nxt     = valid_r;
    cmd_nxt       = cmd_r;
    h_nxt         = h_r;
    size_nxt      = size_r;
    sen_nxt       = sen_r;
    sval_nxt      = sval_r;
    pid_nxt       = pid_r;
    ent_nxt       = ent_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    ram_we        = 1'b0;
    ram_raddr     = k_r[IDX_W-1:0];
    ent_w         = ent_r;
    fin           = 1'b0;

    if (cfg_wr) begin
      if (cfg_sel == ubdt_pkg::CFG_CAPACITY) begin
        capacity_nxt = pwdata[9:0];
      end else begin
        origin_nxt = pwdata[11:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        ram_raddr = idle_h;
        if (start) begin
          cmd_nxt  = in_cmd;
          h_nxt    = idle_h;
          size_nxt = in_byte_size;
          sen_nxt  = in_sync_enable;
          sval_nxt = in_sync_value;
          pid_nxt  = in_token_pid;
          case (in_cmd)
            ubdt_pkg::CMD_INIT: begin
              valid_nxt     = '0;
              alloc_end_nxt = {1'b0, origin_r};
              highest_nxt   = '0;
              fin           = 1'b1;
            end
            ubdt_pkg::CMD_SETUP: begin
              if (!ep_ok || in_byte_size == 10'd0 || {1'b0, setup_h} >= NUM_LIM) begin
                res_w.status = ubdt_pkg::ST_BADPARM;
                fin          = 1'b1;
              end else if (setup_h < 6'(highest_r)) begin
                res_w.status = ubdt_pkg::ST_ERROR;
                fin          = 1'b1;
              end else begin
                state_nxt = S_EVAL;
              end
            end
            ubdt_pkg::CMD_LOOKUP: begin
              if (!ep_ok) begin
                res_w.status = ubdt_pkg::ST_BADPARM;
              end else begin
                res_w.handle = setup_h;
              end
              fin = 1'b1;
            end
            ubdt_pkg::CMD_RELEASE: begin
              if (!range_ok) begin
                fin = 1'b1;
              end else begin
                state_nxt = S_EVAL;
              end
            end
            ubdt_pkg::CMD_SENT, ubdt_pkg::CMD_SEND: begin
              if (!range_ok || !is_in) begin
                res_w.status = ubdt_pkg::ST_BADPARM;
                fin          = 1'b1;
              end else begin
                state_nxt = S_EVAL;
              end
            end
            ubdt_pkg::CMD_RECEIVE: begin
              if (!range_ok || is_in) begin
                res_w.status = ubdt_pkg::ST_BADPARM;
                fin          = 1'b1;
              end else begin
                state_nxt = S_EVAL;
              end
            end
            ubdt_pkg::CMD_PID, ubdt_pkg::CMD_CLAIM, ubdt_pkg::CMD_GETBUF,
            ubdt_pkg::CMD_STALL, ubdt_pkg::CMD_SYNC, ubdt_pkg::CMD_SIE_DONE: begin
              if (!range_ok) begin
                res_w.status = ubdt_pkg::ST_BADPARM;
                fin          = 1'b1;
              end else begin
                state_nxt = S_EVAL;
              end
            end
            default: begin
              res_w.status = ubdt_pkg::ST_BADPARM;
              fin          = 1'b1;
            end
          endcase
        end
      end

      S_EVAL: begin
        ent_nxt = rd_ent;
        ent_w   = rd_ent;
        case (cmd_r)
          ubdt_pkg::CMD_SETUP: begin
            if (rd_ent.addr != 13'd0) begin
              res_w.status = ubdt_pkg::ST_ERROR;
            end else if (nomem) begin
              res_w.status = ubdt_pkg::ST_NOMEM;
            end else begin
              ent_w.status    = {rd_ent.status[7:2], size_r[9:8]};
              ent_w.count_low = size_r[7:0];
              ent_w.addr      = alloc_end_r;
              ram_we          = 1'b1;
              alloc_end_nxt   = alloc_end_r + {3'b0, size_r};
              highest_nxt     = h_r;
            end
            fin = 1'b1;
          end
          ubdt_pkg::CMD_RELEASE: begin
            ent_w.status[ubdt_pkg::B_UOWN] = 1'b1;
            ram_we = 1'b1;
            fin    = 1'b1;
          end
          ubdt_pkg::CMD_CLAIM: begin
            ent_w.status[ubdt_pkg::B_UOWN] = 1'b0;
            ram_we = 1'b1;
            fin    = 1'b1;
          end
          ubdt_pkg::CMD_PID: begin
            if (owned) begin
              res_w.status = ubdt_pkg::ST_ACCESS;
            end else begin
              res_w.pid = rd_ent.status[5:2];
            end
            fin = 1'b1;
          end
          ubdt_pkg::CMD_SENT: begin
            if (owned) begin
              res_w.status = ubdt_pkg::ST_ACCESS;
            end else begin
              res_w.count = {rd_ent.status[1:0], rd_ent.count_low};
            end
            fin = 1'b1;
          end
          ubdt_pkg::CMD_SYNC: begin
            if (owned) begin
              res_w.status = ubdt_pkg::ST_ACCESS;
            end else begin
              ent_w.status[ubdt_pkg::B_DTSEN] = sen_r;
              ent_w.status[ubdt_pkg::B_DTS]   = sval_r;
              ram_we = 1'b1;
            end
            fin = 1'b1;
          end
          ubdt_pkg::CMD_SIE_DONE: begin
            ent_w.status    = {1'b0, rd_ent.status[ubdt_pkg::B_DTS], pid_r, size_r[9:8]};
            ent_w.count_low = size_r[7:0];
            ram_we = 1'b1;
            fin    = 1'b1;
          end
          ubdt_pkg::CMD_GETBUF: begin
            if (owned) begin
              res_w.status = ubdt_pkg::ST_ACCESS;
              fin          = 1'b1;
            end else if (rd_ent.addr == 13'd0) begin
              res_w.status = ubdt_pkg::ST_ERROR;
              fin          = 1'b1;
            end else if (h_r[0]) begin
              k_nxt     = K_W'(h_r) + K_W'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end else begin
              res_w.addr  = rd_ent.addr;
              res_w.count = {rd_ent.status[1:0], rd_ent.count_low};
              fin         = 1'b1;
            end
          end
          ubdt_pkg::CMD_STALL, ubdt_pkg::CMD_RECEIVE, ubdt_pkg::CMD_SEND: begin
            if (owned) begin
              res_w.status = ubdt_pkg::ST_ACCESS;
              fin          = 1'b1;
            end else begin
              k_nxt     = K_W'(h_r) + K_W'(1);
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            res_w.status = ubdt_pkg::ST_BADPARM;
            fin          = 1'b1;
          end
        endcase
      end

      S_SCAN: begin
        if (hit || k_done) begin
          fin = 1'b1;
          case (cmd_r)
            ubdt_pkg::CMD_GETBUF: begin
              res_w.addr  = ent_r.addr;
              res_w.count = scan_size[9:0];
            end
            ubdt_pkg::CMD_STALL, ubdt_pkg::CMD_RECEIVE: begin
              ent_w.status    = {ent_r.status[7:2], scan_size[9:8]};
              ent_w.count_low = scan_size[7:0];
              ent_w.status[ubdt_pkg::B_BSTALL] = (cmd_r == ubdt_pkg::CMD_STALL);
              ent_w.status[ubdt_pkg::B_UOWN]   = 1'b1;
              ram_we = 1'b1;
            end
            ubdt_pkg::CMD_SEND: begin
              if (scan_size < {3'b0, size_r}) begin
                res_w.status = ubdt_pkg::ST_BADPARM;
              end else begin
                ent_w.status    = {ent_r.status[7:2], size_r[9:8]};
                ent_w.count_low = size_r[7:0];
                ent_w.status[ubdt_pkg::B_BSTALL] = 1'b0;
                ent_w.status[ubdt_pkg::B_UOWN]   = 1'b1;
                ram_we = 1'b1;
              end
            end
            default: begin
              res_w.status = ubdt_pkg::ST_BADPARM;
            end
          endcase
        end else begin
          ram_raddr = k_r[IDX_W-1:0];
          k_nxt     = k_r + K_W'(1);
          pend_nxt  = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ram_we) begin
      valid_nxt[h_r] = 1'b1;
    end

    if (fin) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res_w;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    cmd_r    <= cmd_nxt;
    h_r      <= h_nxt;
    size_r   <= size_nxt;
    sen_r    <= sen_nxt;
    sval_r   <= sval_nxt;
    pid_r    <= pid_nxt;
    ent_r    <= ent_nxt;
    k_r      <= k_nxt;
    pend_r   <= pend_nxt;
    rd_idx_r <= ram_raddr;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      origin_r    <= ubdt_pkg::ORIGIN_RST;
      capacity_r  <= ubdt_pkg::CAPACITY_RST;
      alloc_end_r <= {1'b0, ubdt_pkg::ORIGIN_RST};
      highest_r   <= '0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      origin_r    <= origin_nxt;
      capacity_r  <= capacity_nxt;
      alloc_end_r <= alloc_end_nxt;
      highest_r   <= highest_nxt;
      valid_r     <= valid_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_handle_out  = res_r.handle;
  assign out_pid_out     = res_r.pid;
  assign out_buf_address = res_r.addr;
  assign out_byte_count  = res_r.count;

endmodule

`default_nettype wire

// ===== rtl/ubdt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ubdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/ubdt_checker.sv =====
// ----------------------------------------------------------------------------
// Buffer descriptor table checker
// Port-level checks on command acceptance and result words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ubdt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [3:0]  in_command,
  input wire logic [5:0]  in_bd_index,
  input wire logic [4:0]  in_endpoint_number,
  input wire logic        in_direction_in,
  input wire logic [9:0]  in_byte_size,
  input wire logic        in_sync_enable,
  input wire logic        in_sync_value,
  input wire logic [3:0]  in_token_pid,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [5:0]  out_handle_out,
  input wire logic [3:0]  out_pid_out,
  input wire logic [12:0] out_buf_address,
  input wire logic [9:0]  out_byte_count,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // Every result word follows an accepted command or the end of a busy period.
  `ASSERT_SAME(a_result_has_cause, clk, rst_n, out_valid, $past(start && !busy) || $past(busy))

  // When busy drops, the finishing command shows its result in that cycle.
  `ASSERT_SAME(a_busy_end_result, clk, rst_n, $fell(busy) && $past(rst_n), out_valid)

  // A failed command reports nothing but its status.
  `ASSERT_SAME(a_fail_fields_zero, clk, rst_n,
    out_valid && (out_status != ubdt_pkg::ST_OK),
    (out_handle_out == 6'd0) && (out_pid_out == 4'd0) &&
    (out_buf_address == 13'd0) && (out_byte_count == 10'd0))

  // Only the defined status codes appear.
  `ASSERT_SAME(a_status_code, clk, rst_n, out_valid, out_status <= ubdt_pkg::ST_ACCESS)

endmodule

bind usb_buffer_descriptor_table ubdt_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/usb_buffer_descriptor_table_test.sv =====
// ----------------------------------------------------------------------------
// USB buffer descriptor table testbench
// Drives descriptor commands through the start/busy port and checks every
// result word against a predictor that keeps its own copy of the table. The
// buffer region registers are set through the APB port between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_buffer_descriptor_table_test;
  import ubdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int NUM_BD = NUM_DESCRIPTORS_DEF;
  localparam int MAX_EP = MAX_ENDPOINTS_DEF;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int DRAIN_CYCLES = 50;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTED = 40;

  localparam logic [3:0] CMD_SPARE_FIRST = 4'd13;
  localparam logic [3:0] CMD_SPARE_LAST = 4'd15;
  localparam logic [2:0] ADDR_ORIGIN = {CFG_ORIGIN, 2'b00};
  localparam logic [2:0] ADDR_CAPACITY = {CFG_CAPACITY, 2'b00};

  typedef struct packed {
    logic [3:0] command;
    logic [5:0] bd_index;
    logic [4:0] ep;
    logic       dir;
    logic [9:0] size;
    logic       sen;
    logic       sval;
    logic [3:0] pid;
  } cmd_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_command = '0;
  logic [5:0]  in_bd_index = '0;
  logic [4:0]  in_endpoint_number = '0;
  logic        in_direction_in = 1'b0;
  logic [9:0]  in_byte_size = '0;
  logic        in_sync_enable = 1'b0;
  logic        in_sync_value = 1'b0;
  logic [3:0]  in_token_pid = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [5:0]  out_handle_out;
  logic [3:0]  out_pid_out;
  logic [12:0] out_buf_address;
  logic [9:0]  out_byte_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted table contents and region registers.
  logic [7:0]  bd_status_m [NUM_BD];
  logic [7:0]  bd_count_m [NUM_BD];
  logic [12:0] bd_addr_m [NUM_BD];
  logic [12:0] carve_end;
  int          top_handle;
  logic [11:0] origin_reg;
  logic [9:0]  capacity_reg;

  result_t pending_results[$];
  int      mismatches = 0;
  int      words_sent = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;

  usb_buffer_descriptor_table u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_bd_index        (in_bd_index),
    .in_endpoint_number (in_endpoint_number),
    .in_direction_in    (in_direction_in),
    .in_byte_size       (in_byte_size),
    .in_sync_enable     (in_sync_enable),
    .in_sync_value      (in_sync_value),
    .in_token_pid       (in_token_pid),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_handle_out     (out_handle_out),
    .out_pid_out        (out_pid_out),
    .out_buf_address    (out_buf_address),
    .out_byte_count     (out_byte_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_table();
    for (int i = 0; i < NUM_BD; i++) begin
      bd_status_m[i] = '0;
      bd_count_m[i] = '0;
      bd_addr_m[i] = '0;
    end
    carve_end = 13'(origin_reg);
    top_handle = 0;
  endfunction

  // The size of an entry runs to the next allocated entry up to the highest
  // set-up handle, or else to the end of the carved region.
  function automatic logic [12:0] entry_size(input int h);
    for (int k = h + 1; k <= top_handle && k < NUM_BD; k++) begin
      if (bd_addr_m[k] != '0) begin
        return bd_addr_m[k] - bd_addr_m[h];
      end
    end
    return carve_end - bd_addr_m[h];
  endfunction

  function automatic void store_count(input int h, input logic [12:0] n);
    bd_count_m[h] = n[7:0];
    bd_status_m[h][1:0] = n[9:8];
  endfunction

  function automatic status_t setup_entry(input logic [4:0] ep, input logic dir,
                                          input logic [9:0] size);
    int h;
    logic [12:0] used;
    if (ep >= MAX_EP || size == '0) return ST_BADPARM;
    h = {ep, dir};
    if (h >= NUM_BD) return ST_BADPARM;
    if (h < top_handle || bd_addr_m[h] != '0) return ST_ERROR;
    used = carve_end - 13'(origin_reg);
    if (used > capacity_reg || capacity_reg - used < size) return ST_NOMEM;
    bd_addr_m[h] = carve_end;
    carve_end = carve_end + 13'(size);
    top_handle = h;
    store_count(h, entry_size(h));
    return ST_OK;
  endfunction

  function automatic result_t predict_command(input cmd_word_t w);
    result_t res;
    int h;
    logic range_ok;
    logic is_in;
    logic owned;
    res = '0;
    res.status = ST_OK;
    h = w.bd_index;
    range_ok = (h < NUM_BD);
    is_in = w.bd_index[0];
    owned = range_ok ? bd_status_m[h][B_UOWN] : 1'b0;
    case (w.command)
      CMD_INIT: begin
        clear_table();
      end
      CMD_SETUP: begin
        res.status = setup_entry(w.ep, w.dir, w.size);
      end
      CMD_LOOKUP: begin
        if (w.ep >= MAX_EP) res.status = ST_BADPARM;
        else res.handle = {w.ep, w.dir};
      end
      CMD_PID: begin
        if (!range_ok) res.status = ST_BADPARM;
        else if (owned) res.status = ST_ACCESS;
        else res.pid = bd_status_m[h][5:2];
      end
      CMD_RELEASE: begin
        if (range_ok) bd_status_m[h][B_UOWN] = 1'b1;
      end
      CMD_CLAIM: begin
        if (!range_ok) res.status = ST_BADPARM;
        else bd_status_m[h][B_UOWN] = 1'b0;
      end
      CMD_GETBUF: begin
        if (!range_ok) res.status = ST_BADPARM;
        else if (owned) res.status = ST_ACCESS;
        else if (bd_addr_m[h] == '0) res.status = ST_ERROR;
        else begin
          res.addr = bd_addr_m[h];
          res.count = is_in ? entry_size(h) : {bd_status_m[h][1:0], bd_count_m[h]};
        end
      end
      CMD_SENT: begin
        if (!range_ok || !is_in) res.status = ST_BADPARM;
        else if (owned) res.status = ST_ACCESS;
        else res.count = {bd_status_m[h][1:0], bd_count_m[h]};
      end
      CMD_STALL: begin
        if (!range_ok) res.status = ST_BADPARM;
        else if (owned) res.status = ST_ACCESS;
        else begin
          bd_status_m[h][B_BSTALL] = 1'b1;
          store_count(h, entry_size(h));
          bd_status_m[h][B_UOWN] = 1'b1;
        end
      end
      CMD_RECEIVE: begin
        if (!range_ok || is_in) res.status = ST_BADPARM;
        else if (owned) res.status = ST_ACCESS;
        else begin
          store_count(h, entry_size(h));
          bd_status_m[h][B_BSTALL] = 1'b0;
          bd_status_m[h][B_UOWN] = 1'b1;
        end
      end
      CMD_SEND: begin
        if (!range_ok || !is_in) res.status = ST_BADPARM;
        else if (owned) res.status = ST_ACCESS;
        else if (entry_size(h) < 13'(w.size)) res.status = ST_BADPARM;
        else begin
          store_count(h, 13'(w.size));
          bd_status_m[h][B_BSTALL] = 1'b0;
          bd_status_m[h][B_UOWN] = 1'b1;
        end
      end
      CMD_SYNC: begin
        if (!range_ok) res.status = ST_BADPARM;
        else if (owned) res.status = ST_ACCESS;
        else begin
          bd_status_m[h][B_DTSEN] = w.sen;
          bd_status_m[h][B_DTS] = w.sval;
        end
      end
      CMD_SIE_DONE: begin
        if (!range_ok) res.status = ST_BADPARM;
        else begin
          bd_count_m[h] = w.size[7:0];
          bd_status_m[h] = {1'b0, bd_status_m[h][B_DTS], w.pid, w.size[9:8]};
        end
      end
      default: begin
        res.status = ST_BADPARM;
      end
    endcase
    return res;
  endfunction

  function automatic cmd_word_t rand_word();
    cmd_word_t w;
    w.command = 4'($urandom_range(0, 15));
    w.bd_index = 6'($urandom_range(0, 63));
    w.ep = 5'($urandom_range(0, 31));
    w.dir = 1'($urandom_range(0, 1));
    w.size = 10'($urandom_range(0, 1023));
    w.sen = 1'($urandom_range(0, 1));
    w.sval = 1'($urandom_range(0, 1));
    w.pid = 4'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic logic [3:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return CMD_GETBUF;
    if (r < 20) return CMD_SENT;
    if (r < 28) return CMD_STALL;
    if (r < 38) return CMD_RECEIVE;
    if (r < 50) return CMD_SEND;
    if (r < 58) return CMD_SYNC;
    if (r < 73) return CMD_SIE_DONE;
    if (r < 81) return CMD_PID;
    if (r < 87) return CMD_CLAIM;
    if (r < 92) return CMD_RELEASE;
    if (r < 96) return CMD_LOOKUP;
    if (r < 98) return CMD_SETUP;
    if (r < 99) return CMD_INIT;
    return CMD_SPARE_FIRST + 4'($urandom_range(0, CMD_SPARE_LAST - CMD_SPARE_FIRST));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("ERROR: %0t: %s", $realtime, msg);
  endtask

  // The sender works in bursts; start stays high from one word to the next
  // within a burst and drops for a random gap between bursts.
  task automatic send_word(input cmd_word_t w);
    start <= 1'b1;
    in_command <= w.command;
    in_bd_index <= w.bd_index;
    in_endpoint_number <= w.ep;
    in_direction_in <= w.dir;
    in_byte_size <= w.size;
    in_sync_enable <= w.sen;
    in_sync_value <= w.sval;
    in_token_pid <= w.pid;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_command(w));
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_fields(input logic [3:0] cmd, input logic [5:0] h, input logic [4:0] ep,
                             input logic dir, input logic [9:0] size, input logic sen,
                             input logic sval, input logic [3:0] pid);
    send_word('{cmd, h, ep, dir, size, sen, sval, pid});
  endtask

  task automatic pause_sender();
    if (start) start <= 1'b0;
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    pause_sender();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ORIGIN) origin_reg = data[11:0];
    else if (addr == ADDR_CAPACITY) capacity_reg = data[9:0];
  endtask

  task automatic set_region(input int origin, input int capacity);
    write_register(ADDR_ORIGIN, 32'(origin));
    write_register(ADDR_CAPACITY, 32'(capacity));
  endtask

  // One session clears the table, tries to carve a few buffers in non-descending
  // endpoint order and then works on them, with some stray handles mixed in.
  task automatic run_session(input int n_ops);
    int handles[$];
    int n_setup;
    int ep;
    int share;
    int r;
    cmd_word_t w;
    w = rand_word();
    w.command = CMD_INIT;
    send_word(w);
    n_setup = $urandom_range(1, 8);
    ep = $urandom_range(0, 3);
    share = capacity_reg / n_setup;
    if (share < 1) share = 1;
    for (int i = 0; i < n_setup && ep < 18; i++) begin
      w = rand_word();
      w.command = CMD_SETUP;
      w.ep = 5'(ep);
      w.size = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                           : 10'($urandom_range(1, share));
      send_word(w);
      handles.push_back(int'({w.ep, w.dir}));
      ep += $urandom_range(0, 3);
    end
    repeat (n_ops) begin
      w = rand_word();
      w.command = pick_command();
      r = $urandom_range(0, 9);
      if (r < 7) w.bd_index = 6'(handles[$urandom_range(0, handles.size() - 1)]);
      else if (r < 9) w.bd_index = 6'($urandom_range(0, NUM_BD - 1));
      if (w.command == CMD_SEND && $urandom_range(0, 1) == 1) begin
        w.size = 10'($urandom_range(0, 64));
      end
      send_word(w);
    end
  endtask

  task automatic run_traffic(input int n_words);
    int target;
    target = words_sent + n_words;
    while (words_sent < target) run_session($urandom_range(20, 60));
  endtask

  task automatic test_directed_commands();
    send_fields(CMD_LOOKUP, 6'd0, 5'd31, 1'b1, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_LOOKUP, 6'd0, 5'd15, 1'b1, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_GETBUF, 6'd2, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SETUP, 6'd0, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SETUP, 6'd0, 5'd16, 1'b0, 10'd8, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SETUP, 6'd0, 5'd0, 1'b0, 10'd64, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SETUP, 6'd0, 5'd1, 1'b1, 10'd100, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SETUP, 6'd0, 5'd0, 1'b1, 10'd8, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SETUP, 6'd0, 5'd15, 1'b1, 10'd1023, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SETUP, 6'd0, 5'd15, 1'b1, 10'd604, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_GETBUF, 6'd3, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_GETBUF, 6'd0, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SEND, 6'd3, 5'd0, 1'b0, 10'd101, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SEND, 6'd3, 5'd0, 1'b0, 10'd100, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SENT, 6'd3, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SIE_DONE, 6'd3, 5'd0, 1'b0, 10'd1023, 1'b1, 1'b1, 4'd15);
    send_fields(CMD_SENT, 6'd3, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_PID, 6'd3, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_RECEIVE, 6'd3, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_RECEIVE, 6'd0, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SENT, 6'd0, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_STALL, 6'd31, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_CLAIM, 6'd31, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SYNC, 6'd31, 5'd0, 1'b0, 10'd0, 1'b1, 1'b1, 4'd0);
    send_fields(CMD_RELEASE, 6'd40, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_CLAIM, 6'd63, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SPARE_FIRST, 6'd1, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_SPARE_LAST, 6'd1, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
    send_fields(CMD_INIT, 6'd0, 5'd0, 1'b0, 10'd0, 1'b0, 1'b0, 4'd0);
  endtask

  // Region corners: the highest origin, a one-byte region and an origin of
  // zero, where the first buffer lands at address zero and looks unallocated.
  task automatic test_region_extremes();
    set_region(4095, 1023);
    run_traffic(150);
    set_region(1, 1);
    run_traffic(150);
    set_region(0, 512);
    run_traffic(150);
    set_region(4095, 1);
    run_traffic(150);
  endtask

  task automatic test_random_traffic();
    set_region($urandom_range(1, 4095), $urandom_range(1, 1023));
    run_traffic(200);
    set_region($urandom_range(1, 4095), $urandom_range(1, 1023));
    run_traffic(200);
    set_region(ORIGIN_RST, CAPACITY_RST);
    run_traffic(200);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending, status %0d", out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_handle_out !== want.handle)
          report_mismatch($sformatf("handle %0d, want %0d", out_handle_out, want.handle));
        if (out_pid_out !== want.pid)
          report_mismatch($sformatf("pid %0d, want %0d", out_pid_out, want.pid));
        if (out_buf_address !== want.addr)
          report_mismatch($sformatf("address %0d, want %0d", out_buf_address, want.addr));
        if (out_byte_count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", out_byte_count, want.count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("usb_buffer_descriptor_table_test NOT OK");
      $finish;
    end
  end

  initial begin
    origin_reg = ORIGIN_RST;
    capacity_reg = CAPACITY_RST;
    clear_table();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_commands();
    test_region_extremes();
    test_random_traffic();
    pause_sender();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("usb_buffer_descriptor_table_test OK");
    end else begin
      $display("usb_buffer_descriptor_table_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
